@@ rtl/ips_patch_stream_parser_unit_defines.svh @@
// Assertion macros for the IPS patch stream parser.
`ifndef IPS_PATCH_STREAM_PARSER_UNIT_DEFINES_SVH
`define IPS_PATCH_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ipsp_pkg.sv @@
`default_nettype none

package ipsp_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        CFG_IDX_INPUT_FILE_SIZE = 1'b0;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Done status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SCRAMBLED = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  // Offset value that ends the record list ("EOF")
  localparam logic [23:0] EOF_MARK = 24'h454F46;

  // Parse phases, one-hot
  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_OFFSET  = 8'b0000_0010,
    PH_SIZE    = 8'b0000_0100,
    PH_DATA    = 8'b0000_1000,
    PH_RUNLEN  = 8'b0001_0000,
    PH_FILL    = 8'b0010_0000,
    PH_TRAILER = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } ipsp_phase_t;

  // One input item
  typedef struct packed {
    logic [7:0] patch_byte;
    logic       is_last;
  } ipsp_item_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [24:0] target_address;
    logic [15:0] run_length;
    logic [7:0]  byte_value;
    logic [1:0]  status;
    logic [24:0] output_length;
  } ipsp_result_t;

  // Expected header byte at each position of "PATCH"
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipsp_in_if.sv @@
`default_nettype none

interface ipsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic       is_last;

  modport source (output valid, output patch_byte, output is_last, input ready);
  modport sink (input valid, input patch_byte, input is_last, output ready);
endinterface

`default_nettype wire

@@ rtl/ipsp_out_if.sv @@
`default_nettype none

interface ipsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [24:0] target_address;
  logic [15:0] run_length;
  logic [7:0]  byte_value;
  logic [1:0]  status;
  logic [24:0] output_length;

  modport source (
    output valid, output kind, output target_address, output run_length,
    output byte_value, output status, output output_length, input ready
  );
  modport sink (
    input valid, input kind, input target_address, input run_length,
    input byte_value, input status, input output_length, output ready
  );
endinterface

`default_nettype wire

@@ rtl/ipsp_cfg_regs.sv @@
`default_nettype none

module ipsp_cfg_regs import ipsp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output logic      [23:0]           input_file_size
);

  logic [23:0] ifs_r;
  logic        hit;

  // Decode the register slot from bit 2 of the byte address
  assign hit    = (paddr[2] == CFG_IDX_INPUT_FILE_SIZE);
  assign pready = 1'b1;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ifs_r <= '0;
    end else if (psel && penable && pwrite && pready && hit) begin
      ifs_r <= pwdata[23:0];
    end
  end

  // Read back
  assign prdata          = hit ? {8'h00, ifs_r} : 32'h0000_0000;
  assign input_file_size = ifs_r;

endmodule

`default_nettype wire

@@ rtl/ipsp_in_stage.sv @@
`default_nettype none

module ipsp_in_stage import ipsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ipsp_in_if.sink    in_chan,
  input  wire logic  take,
  output logic       item_valid,
  output ipsp_item_t item
);

  logic       valid_r;
  ipsp_item_t item_r;
  logic       in_fire;

  // Accept a new item whenever the register is empty or drains this cycle
  assign in_chan.ready = !valid_r || take;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_fire) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.patch_byte <= in_chan.patch_byte;
      item_r.is_last    <= in_chan.is_last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

@@ rtl/ipsp_parser.sv @@
`default_nettype none

module ipsp_parser import ipsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire ipsp_item_t  item,
  input  wire logic [23:0] input_file_size,
  output logic             res_valid,
  output ipsp_result_t     res,
  output ipsp_phase_t      parse_phase
);

  ipsp_phase_t phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [23:0] offset_r, offset_nxt;
  logic [15:0] size_r, size_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [23:0] prev_r, prev_nxt;
  logic [24:0] ext_r, ext_nxt;
  logic        scr_r, scr_nxt;
  logic [23:0] tval_r, tval_nxt;
  logic [2:0]  tcnt_r, tcnt_nxt;

  logic [7:0]  b;
  logic [23:0] offset_shift;
  logic [15:0] size_shift;
  logic [24:0] ext_sum;
  logic [15:0] remain_dec;
  logic        emit;
  logic [1:0]  kind;
  logic [24:0] addr;
  logic [15:0] run;
  logic [7:0]  val;

  logic        tail_ok;
  logic [24:0] tval_ext;
  logic [24:0] ifs_ext;
  logic [24:0] lo;
  logic [24:0] ic;
  logic [24:0] len;
  logic        scr_done;

  assign b            = item.patch_byte;
  assign offset_shift = {offset_r[15:0], b};
  assign size_shift   = {size_r[7:0], b};
  assign ext_sum      = {1'b0, offset_r} + {9'd0, size_shift};
  assign remain_dec   = remain_r - 16'd1;

  // Advance the record parser by one byte
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    offset_nxt = offset_r;
    size_nxt   = size_r;
    remain_nxt = remain_r;
    prev_nxt   = prev_r;
    ext_nxt    = ext_r;
    scr_nxt    = scr_r;
    tval_nxt   = tval_r;
    tcnt_nxt   = tcnt_r;
    emit       = 1'b0;
    kind       = KIND_WRITE;
    addr       = '0;
    run        = '0;
    val        = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (idx_r > 3'd4 || b != magic_byte(idx_r)) begin
          phase_nxt = PH_ERROR;
        end else if (idx_r == 3'd4) begin
          phase_nxt  = PH_OFFSET;
          idx_nxt    = '0;
          offset_nxt = '0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_OFFSET: begin
        offset_nxt = offset_shift;
        if (idx_r >= 3'd2) begin
          idx_nxt = '0;
          if (offset_shift == EOF_MARK) begin
            phase_nxt = PH_TRAILER;
            tval_nxt  = '0;
            tcnt_nxt  = '0;
          end else begin
            if (offset_shift < prev_r) begin
              scr_nxt = 1'b1;
            end
            prev_nxt  = offset_shift;
            size_nxt  = '0;
            phase_nxt = PH_SIZE;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_SIZE: begin
        size_nxt = size_shift;
        if (idx_r >= 3'd1) begin
          idx_nxt = '0;
          if (size_shift == 16'd0) begin
            phase_nxt = PH_RUNLEN;
          end else begin
            if (ext_sum > ext_r) begin
              ext_nxt = ext_sum;
            end
            remain_nxt = size_shift;
            phase_nxt  = PH_DATA;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_DATA: begin
        emit       = 1'b1;
        kind       = KIND_WRITE;
        addr       = {1'b0, offset_r} + {9'd0, size_r - remain_r};
        val        = b;
        remain_nxt = remain_dec;
        if (remain_dec == 16'd0) begin
          phase_nxt  = PH_OFFSET;
          offset_nxt = '0;
        end
      end
      PH_RUNLEN: begin
        size_nxt = size_shift;
        if (idx_r >= 3'd1) begin
          idx_nxt = '0;
          if (size_shift == 16'd0) begin
            phase_nxt = PH_ERROR;
          end else begin
            if (ext_sum > ext_r) begin
              ext_nxt = ext_sum;
            end
            phase_nxt = PH_FILL;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_FILL: begin
        emit       = 1'b1;
        kind       = KIND_FILL;
        addr       = {1'b0, offset_r};
        run        = size_r;
        val        = b;
        phase_nxt  = PH_OFFSET;
        offset_nxt = '0;
      end
      PH_TRAILER: begin
        if (tcnt_r < 3'd3) begin
          tval_nxt = {tval_r[15:0], b};
          tcnt_nxt = tcnt_r + 3'd1;
        end else begin
          tcnt_nxt  = 3'd4;
          phase_nxt = PH_ERROR;
        end
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  // Final length and status; extent and scramble state do not change on the way
  // into or through the trailer, so the held values serve
  assign tail_ok  = (phase_nxt == PH_TRAILER) && (tcnt_nxt == 3'd0 || tcnt_nxt == 3'd3);
  assign tval_ext = {1'b0, tval_nxt};
  assign ifs_ext  = {1'b0, input_file_size};

  always_comb begin
    lo       = ext_r;
    ic       = ifs_ext;
    scr_done = scr_r;
    if (tcnt_nxt == 3'd3) begin
      if (ext_r > tval_ext) begin
        lo       = tval_ext;
        scr_done = 1'b1;
      end
      if (tval_ext < ifs_ext) begin
        ic = tval_ext;
      end
    end
    len = (lo > ic) ? lo : ic;
  end

  // Build the result item
  always_comb begin
    res = '0;
    if (item.is_last) begin
      res.kind = KIND_DONE;
      if (tail_ok) begin
        res.status        = scr_done ? ST_SCRAMBLED : ST_OK;
        res.output_length = len;
      end else begin
        res.status = ST_INVALID;
      end
    end else begin
      res.kind           = kind;
      res.target_address = addr;
      res.run_length     = run;
      res.byte_value     = val;
    end
  end

  assign res_valid = emit || item.is_last;

  // Hold state; clear everything after the last byte of a patch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= '0;
      offset_r <= '0;
      size_r   <= '0;
      remain_r <= '0;
      prev_r   <= '0;
      ext_r    <= '0;
      scr_r    <= 1'b0;
      tval_r   <= '0;
      tcnt_r   <= '0;
    end else if (fire) begin
      if (item.is_last) begin
        phase_r  <= PH_HEADER;
        idx_r    <= '0;
        offset_r <= '0;
        size_r   <= '0;
        remain_r <= '0;
        prev_r   <= '0;
        ext_r    <= '0;
        scr_r    <= 1'b0;
        tval_r   <= '0;
        tcnt_r   <= '0;
      end else begin
        phase_r  <= phase_nxt;
        idx_r    <= idx_nxt;
        offset_r <= offset_nxt;
        size_r   <= size_nxt;
        remain_r <= remain_nxt;
        prev_r   <= prev_nxt;
        ext_r    <= ext_nxt;
        scr_r    <= scr_nxt;
        tval_r   <= tval_nxt;
        tcnt_r   <= tcnt_nxt;
      end
    end
  end

  assign parse_phase = phase_r;

endmodule

`default_nettype wire

@@ rtl/ipsp_out_stage.sv @@
`default_nettype none

module ipsp_out_stage import ipsp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire logic         res_valid,
  input  wire ipsp_result_t res,
  output logic              space,
  ipsp_out_if.source        out_chan
);

  logic         valid_r;
  ipsp_result_t res_r;

  // Room for a new result when empty or when the held one leaves now
  assign space = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.kind           = res_r.kind;
  assign out_chan.target_address = res_r.target_address;
  assign out_chan.run_length     = res_r.run_length;
  assign out_chan.byte_value     = res_r.byte_value;
  assign out_chan.status         = res_r.status;
  assign out_chan.output_length  = res_r.output_length;

endmodule

`default_nettype wire

@@ rtl/ips_patch_stream_parser_unit.sv @@
// IPS patch stream parser: one patch byte in, at most one write, fill or done item out.
// Each byte passes the input register, then the result register once that has room.
// Throughput: 1 byte per cycle if output is ready; parsing is one logic pass on parser state.
// Reset (rst_n low, synchronous): pipeline empty, parser expects header, size register 0.
// After each done item the parser returns to expecting a header; the register is kept.
`default_nettype none

`include "ips_patch_stream_parser_unit_defines.svh"

module ips_patch_stream_parser_unit import ipsp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ipsp_in_if.sink                    in_chan,
  ipsp_out_if.source                 out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  logic         item_valid;
  ipsp_item_t   item;
  logic         space;
  logic         fire;
  logic         res_valid;
  ipsp_result_t res;
  ipsp_phase_t  parse_phase;
  logic [23:0]  input_file_size;

  // Process the held item when the result register has room
  assign fire = item_valid && space;

  ipsp_cfg_regs u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .input_file_size (input_file_size)
  );

  ipsp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  ipsp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .item            (item),
    .input_file_size (input_file_size),
    .res_valid       (res_valid),
    .res             (res),
    .parse_phase     (parse_phase)
  );

  ipsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_chan  (out_chan)
  );

  // The last byte of a patch always leaves the parser expecting a new header
  `ASSERT_NEXT(a_clear_after_last, clk, rst_n, fire && item.is_last, parse_phase == PH_HEADER)

  // An invalid patch never reports an output length
  `ASSERT_IMPLIES(a_invalid_len_zero, clk, rst_n,
    out_chan.valid && out_chan.kind == KIND_DONE && out_chan.status == ST_INVALID,
    out_chan.output_length == 25'd0)

  // Write and fill items carry no status or length
  `ASSERT_IMPLIES(a_data_no_status, clk, rst_n,
    out_chan.valid && out_chan.kind != KIND_DONE,
    out_chan.status == ST_OK && out_chan.output_length == 25'd0)

  // The last byte always produces a done item
  `ASSERT_NEXT(a_last_gives_done, clk, rst_n, fire && item.is_last,
    out_chan.valid && out_chan.kind == KIND_DONE)

endmodule

`default_nettype wire

@@ tb/tb_ips_patch_stream_parser_unit.sv @@
`timescale 1ns / 100ps

module tb_ips_patch_stream_parser_unit import ipsp_pkg::*;;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 6;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int ITEMS_PER_PHASE  = 170;
  localparam int NUM_PHASES       = 5;
  localparam int TIMEOUT_CYCLES   = 400000;
  localparam logic [39:0] HDR_TEXT = "PATCH";
  localparam logic [CFG_ADDR_W-1:0] ADDR_INPUT_FILE_SIZE = {CFG_IDX_INPUT_FILE_SIZE, 2'b00};

  typedef enum int {
    PATCH_CLEAN,
    PATCH_TRUNCATED,
    PATCH_BAD_TRAILER,
    PATCH_ZERO_RUN,
    PATCH_BAD_HEADER,
    PATCH_NOISE
  } patch_kind_t;

  // Tracks the parser state and holds the write, fill and done items still owed
  class patch_scoreboard;
    ipsp_phase_t  parse_ph;
    logic [2:0]   idx;
    logic [23:0]  rec_ofs;
    logic [15:0]  rec_size;
    logic [15:0]  remaining;
    logic [23:0]  prev_ofs;
    logic [24:0]  extent;
    bit           scrambled;
    logic [23:0]  trailer;
    logic [2:0]   trailer_cnt;
    logic [23:0]  file_size;
    ipsp_result_t owed_q[$];
    int           errors;
    int           results_seen;

    function new();
      file_size = '0;
      errors = 0;
      results_seen = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      parse_ph = PH_HEADER;
      idx = '0;
      rec_ofs = '0;
      rec_size = '0;
      remaining = '0;
      prev_ofs = '0;
      extent = '0;
      scrambled = 0;
      trailer = '0;
      trailer_cnt = '0;
    endfunction

    function void set_file_size(logic [23:0] value);
      file_size = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void grow_extent();
      logic [24:0] e;
      e = 25'(rec_ofs) + 25'(rec_size);
      if (e > extent) extent = e;
    endfunction

    // Advance the parser by one patch byte and queue what it produces
    function void note_input(logic [7:0] b, logic last);
      bit           emit;
      bit           scr;
      ipsp_result_t r;
      logic [24:0]  lo;
      logic [23:0]  ic;
      emit = 0;
      r = '0;
      case (parse_ph)
        PH_HEADER: begin
          if (idx > 3'd4 || b != HDR_TEXT[8*(4-idx) +: 8]) begin
            parse_ph = PH_ERROR;
          end else if (idx == 3'd4) begin
            parse_ph = PH_OFFSET;
            idx = '0;
            rec_ofs = '0;
          end else begin
            idx++;
          end
        end
        PH_OFFSET: begin
          rec_ofs = {rec_ofs[15:0], b};
          if (idx >= 3'd2) begin
            idx = '0;
            if (rec_ofs == EOF_MARK) begin
              parse_ph = PH_TRAILER;
              trailer = '0;
              trailer_cnt = '0;
            end else begin
              if (rec_ofs < prev_ofs) scrambled = 1;
              prev_ofs = rec_ofs;
              rec_size = '0;
              parse_ph = PH_SIZE;
            end
          end else begin
            idx++;
          end
        end
        PH_SIZE: begin
          rec_size = {rec_size[7:0], b};
          if (idx >= 3'd1) begin
            idx = '0;
            if (rec_size == 16'd0) begin
              parse_ph = PH_RUNLEN;
            end else begin
              grow_extent();
              remaining = rec_size;
              parse_ph = PH_DATA;
            end
          end else begin
            idx++;
          end
        end
        PH_DATA: begin
          emit = 1;
          r.kind = KIND_WRITE;
          r.target_address = 25'(rec_ofs) + 25'(16'(rec_size - remaining));
          r.byte_value = b;
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            parse_ph = PH_OFFSET;
            rec_ofs = '0;
          end
        end
        PH_RUNLEN: begin
          rec_size = {rec_size[7:0], b};
          if (idx >= 3'd1) begin
            idx = '0;
            if (rec_size == 16'd0) begin
              parse_ph = PH_ERROR;
            end else begin
              grow_extent();
              parse_ph = PH_FILL;
            end
          end else begin
            idx++;
          end
        end
        PH_FILL: begin
          emit = 1;
          r.kind = KIND_FILL;
          r.target_address = 25'(rec_ofs);
          r.run_length = rec_size;
          r.byte_value = b;
          parse_ph = PH_OFFSET;
          rec_ofs = '0;
        end
        PH_TRAILER: begin
          if (trailer_cnt < 3'd3) begin
            trailer = {trailer[15:0], b};
            trailer_cnt++;
          end else begin
            trailer_cnt = 3'd4;
            parse_ph = PH_ERROR;
          end
        end
        default: parse_ph = PH_ERROR;
      endcase

      // Last byte: close the patch with a done item, drop any pending write or fill
      if (last) begin
        r = '0;
        r.kind = KIND_DONE;
        r.status = ST_INVALID;
        if (parse_ph == PH_TRAILER && (trailer_cnt == 3'd0 || trailer_cnt == 3'd3)) begin
          scr = scrambled;
          if (trailer_cnt == 3'd3) begin
            lo = extent;
            ic = (file_size < trailer) ? file_size : trailer;
            if (lo > 25'(trailer)) begin
              lo = 25'(trailer);
              scr = 1;
            end
            r.output_length = (lo > 25'(ic)) ? lo : 25'(ic);
          end else begin
            r.output_length = (extent > 25'(file_size)) ? extent : 25'(file_size);
          end
          r.status = scr ? ST_SCRAMBLED : ST_OK;
        end
        owed_q.push_back(r);
        clear_parse();
      end else if (emit) begin
        owed_q.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [24:0] got, logic [24:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                         results_seen, name, got, want));
    endtask

    // Match one result item against the oldest owed one
    task check_result(ipsp_result_t got);
      ipsp_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d addr 0x%0h", got.kind,
                         got.target_address));
      end else begin
        want = owed_q.pop_front();
        compare_field("kind", 25'(got.kind), 25'(want.kind));
        compare_field("target_address", got.target_address, want.target_address);
        compare_field("run_length", 25'(got.run_length), 25'(want.run_length));
        compare_field("byte_value", 25'(got.byte_value), 25'(want.byte_value));
        compare_field("status", 25'(got.status), 25'(want.status));
        compare_field("output_length", got.output_length, want.output_length);
      end
      results_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ipsp_in_if  in_ch();
  ipsp_out_if out_ch();

  patch_scoreboard sb = new();

  logic [7:0] patch_q[$];
  bit         src_idle_on;
  bit         sink_idle_on;
  bit         hold_req;
  int         hold_left;
  int         items_sent;

  ips_patch_stream_parser_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Result side: check accepted items, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{kind: out_ch.kind, target_address: out_ch.target_address,
                          run_length: out_ch.run_length, byte_value: out_ch.byte_value,
                          status: out_ch.status, output_length: out_ch.output_length});
      if (hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(sink_idle_on && $urandom_range(99) < 35);
      end
    end
  end

  // Append a value big-endian, nbytes wide
  function automatic void push_be(logic [39:0] value, int nbytes);
    for (int k = nbytes - 1; k >= 0; k--) patch_q.push_back(value[8*k +: 8]);
  endfunction

  // Build one patch of the given flavor into patch_q
  function automatic void build_patch(patch_kind_t pk);
    logic [23:0] ofs;
    logic [15:0] len;
    int          nrec;
    int          cut;
    int          tlen;
    bit          zero_run;
    patch_q.delete();
    if (pk == PATCH_NOISE) begin
      repeat ($urandom_range(1, 6)) push_be($urandom_range(255), 1);
      return;
    end
    push_be(HDR_TEXT, 5);
    if (pk == PATCH_BAD_HEADER) begin
      cut = $urandom_range(4);
      patch_q[cut] = patch_q[cut] ^ (8'h01 << $urandom_range(7));
    end
    nrec = $urandom_range(0, 4);
    if (pk == PATCH_ZERO_RUN && nrec == 0) nrec = 1;
    ofs = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    for (int r = 0; r < nrec; r++) begin
      // mostly ascending offsets, now and then a step back
      if (r != 0)
        ofs = ($urandom_range(9) == 0) ? ofs - 24'($urandom_range(1, 64))
                                       : ofs + 24'($urandom_range(0, 48));
      push_be(ofs, 3);
      zero_run = (pk == PATCH_ZERO_RUN && r == nrec - 1);
      if (zero_run || $urandom_range(3) == 0) begin
        push_be(0, 2);
        if (zero_run)
          len = '0;
        else
          len = ($urandom_range(7) == 0) ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(1, 300));
        push_be(len, 2);
        push_be($urandom_range(255), 1);
      end else begin
        len = ($urandom_range(9) == 0) ? 16'($urandom_range(7, 40))
                                       : 16'($urandom_range(1, 6));
        push_be(len, 2);
        repeat (len) push_be($urandom_range(255), 1);
      end
    end
    push_be(EOF_MARK, 3);
    if (pk == PATCH_BAD_TRAILER) begin
      tlen = $urandom_range(1, 4);
      if (tlen >= 3) tlen++;
    end else begin
      tlen = $urandom_range(1) ? 3 : 0;
    end
    if (tlen == 3) begin
      case ($urandom_range(2))
        0:       push_be(24'hFFFFFF, 3);
        1:       push_be($urandom_range(0, 4000), 3);
        default: push_be($urandom, 3);
      endcase
    end else begin
      repeat (tlen) push_be($urandom_range(255), 1);
    end
    // cut the patch short so the last byte lands anywhere
    if (pk == PATCH_TRUNCATED) begin
      cut = $urandom_range(1, patch_q.size());
      while (patch_q.size() > cut) void'(patch_q.pop_back());
    end
  endfunction

  // Offer one byte, idling at random first, and hold until it is taken
  task automatic send_byte(input logic [7:0] value, input logic last);
    while (src_idle_on && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.patch_byte <= value;
    in_ch.is_last    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(value, last);
    items_sent++;
  endtask

  task automatic send_patch();
    foreach (patch_q[i]) send_byte(patch_q[i], i == patch_q.size() - 1);
  endtask

  // Drop valid and wait for every owed item, then let the pipeline settle
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write the file size register, then read it back
  task automatic write_file_size(input logic [23:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_INPUT_FILE_SIZE;
    pwdata  <= {8'h00, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[23:0] !== value)
      sb.report($sformatf("file size read 0x%0h expected 0x%0h", prdata[23:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_file_size(value);
  endtask

  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("tb_ips_patch_stream_parser_unit: errors");
    $finish;
  end

  initial begin
    logic [23:0]  sizes[NUM_PHASES];
    patch_kind_t  pk;
    int           roll;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.patch_byte = '0;
    in_ch.is_last    = 1'b0;
    out_ch.ready     = 1'b0;
    src_idle_on      = 1;
    sink_idle_on     = 1;
    hold_req         = 0;
    hold_left        = 0;
    sizes = '{24'h000100, 24'hFFFFFF, 24'h000000, 24'($urandom),
              24'($urandom_range(0, 5000))};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_file_size(sizes[ph]);
      // one phase runs with no idling on either side
      src_idle_on  = (ph != 1);
      sink_idle_on = (ph != 1);
      if (ph == 2) hold_req = 1;

      if (ph == 0) begin
        // max offset and max run, offset going back, truncate below extent
        patch_q.delete();
        push_be(HDR_TEXT, 5);
        push_be(24'hFFFFFF, 3);
        push_be(16'h0001, 2);
        push_be(8'hFF, 1);
        push_be(24'h000010, 3);
        push_be(16'h0000, 2);
        push_be(16'hFFFF, 2);
        push_be(8'h00, 1);
        push_be(EOF_MARK, 3);
        push_be(24'h000004, 3);
        send_patch();
        // header mismatch on a lone last byte
        patch_q.delete();
        push_be(8'h51, 1);
        send_patch();
        drain(1);
      end

      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 62)      pk = PATCH_CLEAN;
        else if (roll < 76) pk = PATCH_TRUNCATED;
        else if (roll < 84) pk = PATCH_BAD_TRAILER;
        else if (roll < 90) pk = PATCH_ZERO_RUN;
        else if (roll < 95) pk = PATCH_BAD_HEADER;
        else                pk = PATCH_NOISE;
        build_patch(pk);
        send_patch();
        // now and then hold the sender until everything owed has come out
        if ($urandom_range(7) == 0) drain(1);
      end
      drain(SETTLE_CYCLES);
    end

    if (sb.errors == 0) begin
      $display("tb_ips_patch_stream_parser_unit: clean");
    end else begin
      $display("tb_ips_patch_stream_parser_unit: errors");
    end
    $finish;
  end

endmodule
